// File: design/assert_macros.svh
// Assertion macros shared by the queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/fsr_pkg.sv
// Shared constants, codes and command/status types of the search-purge queue.
package fsr_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int WORD_BITS   = 32;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Action codes of an input item
  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PURGE   = 3'd2,
    OP_FIND    = 3'd3,
    OP_REVERSE = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Offset from the head used to form a store address
  typedef enum logic [1:0] {
    OFF_ZERO  = 2'd0,
    OFF_K     = 2'd1,
    OFF_W     = 2'd2,
    OFF_COUNT = 2'd3
  } off_sel_t;

  // Source of the store write data
  typedef enum logic [1:0] {
    WD_IN    = 2'd0,
    WD_RDATA = 2'd1,
    WD_TMP   = 2'd2
  } wd_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load_res;
    status_t  res_status;
    logic     mem_rd;
    off_sel_t rd_off;
    logic     mem_wr;
    off_sel_t wr_off;
    wd_sel_t  wd_sel;
    logic     cnt_inc;
    logic     pop_take;
    logic     scan_init;
    logic     scan_rd;
    logic     scan_purge;
    logic     find_end;
    logic     purge_end;
    logic     rev_init;
    logic     tmp_ld;
    logic     rev_step;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic cnt_gt1;
    logic k_lt_cnt;
    logic rd_valid;
    logic rev_more;
  } dp_stat_t;

endpackage

// File: design/fsr_datapath.sv
// Datapath of the queue: circular store, pointers, compare stage and result registers.
`include "assert_macros.svh"

module fsr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  fsr_pkg::dp_cmd_t                    cmd,
  input  logic signed [fsr_pkg::WORD_BITS-1:0] value,
  output fsr_pkg::dp_stat_t                   stat,
  output logic signed [fsr_pkg::WORD_BITS-1:0] popped_value,
  output fsr_pkg::status_t                    res_status,
  output logic        [fsr_pkg::CNT_W-1:0]     entry_count
);
  import fsr_pkg::*;

  logic [WORD_BITS-1:0] mem [QUEUE_DEPTH];
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] val;
  logic [WORD_BITS-1:0] tmp;
  logic [WORD_BITS-1:0] wd;
  logic [IDX_W-1:0]     head;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     k;
  logic [CNT_W-1:0]     w;
  logic [CNT_W-1:0]     rd_off_val;
  logic [CNT_W-1:0]     wr_off_val;
  logic [IDX_W-1:0]     ra;
  logic [IDX_W-1:0]     wa;
  logic                 rd_valid;
  logic                 found;
  logic                 eq;
  logic                 purge_wr;
  logic                 we;
  logic                 re;

  // Map an offset from the head onto a slot of the circular store
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] hd,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(hd) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] pick_off(input off_sel_t sel,
                                                input logic [CNT_W-1:0] kk,
                                                input logic [CNT_W-1:0] ww,
                                                input logic [CNT_W-1:0] cc);
    logic [CNT_W-1:0] r;
    case (sel)
      OFF_ZERO:  r = '0;
      OFF_K:     r = kk;
      OFF_W:     r = ww;
      OFF_COUNT: r = cc;
      default:   r = '0;
    endcase
    return r;
  endfunction

  // Compare stage and store addressing
  always_comb begin
    eq         = (rdata == val);
    purge_wr   = cmd.scan_purge & rd_valid & ~eq;
    we         = cmd.mem_wr | purge_wr;
    re         = cmd.mem_rd;
    rd_off_val = pick_off(cmd.rd_off, k, w, count);
    wr_off_val = pick_off(cmd.wr_off, k, w, count);
    ra         = slot_of(head, rd_off_val);
    wa         = slot_of(head, wr_off_val);
    case (cmd.wd_sel)
      WD_IN:    wd = value;
      WD_RDATA: wd = rdata;
      WD_TMP:   wd = tmp;
      default:  wd = value;
    endcase
  end

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata <= mem[ra];
  end

  // Control state: head, count, read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_rd;
      if (cmd.cnt_inc) count <= count + CNT_W'(1);
      if (cmd.pop_take) begin
        head  <= (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
        count <= count - CNT_W'(1);
      end
      if (cmd.purge_end) count <= w;
    end
  end

  // Walk pointers, operand, swap holder and result words
  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      popped_value <= '0;
      res_status   <= cmd.res_status;
    end
    if (cmd.pop_take) popped_value <= rdata;
    if (cmd.scan_init) begin
      k     <= '0;
      w     <= '0;
      found <= 1'b0;
      val   <= value;
    end
    if (cmd.scan_rd) k <= k + CNT_W'(1);
    if (rd_valid && eq) found <= 1'b1;
    if (purge_wr) w <= w + CNT_W'(1);
    if (cmd.find_end) res_status <= found ? ST_DONE : ST_NOT_FOUND;
    if (cmd.purge_end) res_status <= (w == count) ? ST_NOT_FOUND : ST_DONE;
    if (cmd.rev_init) begin
      k <= '0;
      w <= count - CNT_W'(1);
    end
    if (cmd.tmp_ld) tmp <= rdata;
    if (cmd.rev_step) begin
      k <= k + CNT_W'(1);
      w <= w - CNT_W'(1);
    end
  end

  // Report status to the controller
  always_comb begin
    stat.full     = (count == CNT_W'(QUEUE_DEPTH));
    stat.empty    = (count == '0);
    stat.cnt_gt1  = (count > CNT_W'(1));
    stat.k_lt_cnt = (k < count);
    stat.rd_valid = rd_valid;
    stat.rev_more = ((CNT_W+1)'(k) + (CNT_W+1)'(2)) < (CNT_W+1)'(w);
  end

  assign entry_count = count;

  `ASSERT_CLK(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "entry count above queue depth")
  `ASSERT_CLK(a_no_rw_clash, (we && re) |-> (wa != ra), "store read and write hit one slot")
  `ASSERT_CLK(a_purge_keeps_order, purge_wr |-> (w < k), "purge write overtook the read pointer")

endmodule

// File: design/fsr_ctrl.sv
// Controller state machine that sequences each queue action over the datapath.
`include "assert_macros.svh"

module fsr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        action,
  input  fsr_pkg::dp_stat_t stat,
  output fsr_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import fsr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_POP    = 9'b000000010,
    S_FIND   = 9'b000000100,
    S_PURGE  = 9'b000001000,
    S_RLO    = 9'b000010000,
    S_RHI    = 9'b000100000,
    S_WLO    = 9'b001000000,
    S_WHI    = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // Hold the current step
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Decode the step into datapath commands
  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_DONE;
    cmd.rd_off     = OFF_ZERO;
    cmd.wr_off     = OFF_ZERO;
    cmd.wd_sel     = WD_IN;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_res = 1'b1;
          state_next   = S_FINISH;
          case (op_t'(action))
            OP_PUSH: begin
              if (stat.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_off  = OFF_COUNT;
                cmd.wd_sel  = WD_IN;
                cmd.cnt_inc = 1'b1;
              end
            end
            OP_POP: begin
              if (stat.empty) begin
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.mem_rd = 1'b1;
                cmd.rd_off = OFF_ZERO;
                state_next = S_POP;
              end
            end
            OP_PURGE: begin
              cmd.scan_init = 1'b1;
              state_next    = S_PURGE;
            end
            OP_FIND: begin
              cmd.scan_init = 1'b1;
              state_next    = S_FIND;
            end
            OP_REVERSE: begin
              if (stat.cnt_gt1) begin
                cmd.rev_init = 1'b1;
                state_next   = S_RLO;
              end
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_POP: begin
        cmd.pop_take = 1'b1;
        state_next   = S_FINISH;
      end
      S_FIND: begin
        cmd.mem_rd  = stat.k_lt_cnt;
        cmd.scan_rd = stat.k_lt_cnt;
        cmd.rd_off  = OFF_K;
        if (!stat.k_lt_cnt && !stat.rd_valid) begin
          cmd.find_end = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_PURGE: begin
        cmd.mem_rd     = stat.k_lt_cnt;
        cmd.scan_rd    = stat.k_lt_cnt;
        cmd.rd_off     = OFF_K;
        cmd.scan_purge = 1'b1;
        cmd.wr_off     = OFF_W;
        cmd.wd_sel     = WD_RDATA;
        if (!stat.k_lt_cnt && !stat.rd_valid) begin
          cmd.purge_end = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_RLO: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_off = OFF_K;
        state_next = S_RHI;
      end
      S_RHI: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_off = OFF_W;
        cmd.tmp_ld = 1'b1;
        state_next = S_WLO;
      end
      S_WLO: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_off = OFF_K;
        cmd.wd_sel = WD_RDATA;
        state_next = S_WHI;
      end
      S_WHI: begin
        cmd.mem_wr   = 1'b1;
        cmd.wr_off   = OFF_W;
        cmd.wd_sel   = WD_TMP;
        cmd.rev_step = 1'b1;
        state_next   = stat.rev_more ? S_RLO : S_FINISH;
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FINISH);

  `ASSERT_CLK(a_accept_goes_busy, (start && !busy) |=> busy, "accepted item left block idle")
  `ASSERT_CLK(a_done_one_cycle, done |=> !done, "result strobe held over two cycles")

endmodule

// File: design/fifo_with_search_purge_reverse_core.sv
// Top level of the bounded queue with push, pop, purge, search and reverse.
//
// An item (action, value) is taken when start is high and busy is low; exactly
// one result follows, shown for a single cycle with done high, and the receiver
// must take it then. Push, undefined actions, failed pop and short reverse go
// straight to the result; pop first reads the head entry; contains and purge
// walk over the stored entries through the one registered read port of the
// store and then let the last read reach the compare; reverse of n > 1 entries
// does two reads and two writes for each swap on that same store. No clearing
// pass runs after reset.
module fifo_with_search_purge_reverse_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [2:0]                           action,
  input  logic signed [fsr_pkg::WORD_BITS-1:0] value,
  output logic                                 busy,
  output logic                                 done,
  output logic signed [fsr_pkg::WORD_BITS-1:0] popped_value,
  output logic [1:0]                           status,
  output logic [fsr_pkg::CNT_W-1:0]            entry_count
);
  import fsr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_t  res_status;

  // Sequence each action
  fsr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Store and result registers
  fsr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .stat         (stat),
    .popped_value (popped_value),
    .res_status   (res_status),
    .entry_count  (entry_count)
  );

  assign status = res_status;

endmodule
